### rtl/rle_face_image_decoder_unit_macros.svh
// assertion macros for the rle face image decoder unit
// no dependencies; included by the rtl files that carry assertions
`ifndef RLE_FACE_IMAGE_DECODER_UNIT_MACROS_SVH
`define RLE_FACE_IMAGE_DECODER_UNIT_MACROS_SVH
`ifndef SYNTH
`define RFID_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfid: same-cycle check failed");
`define RFID_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfid: next-cycle check failed");
`else
`define RFID_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RFID_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/rfid_pkg.sv
// shared types and constants for the rle face image decoder unit
// no dependencies; used by the controller, datapath and top level
package rfid_pkg;

  localparam int unsigned MaxDim    = 512;
  localparam int unsigned RunW      = 6;
  localparam logic [7:0]  RunBase   = 8'd192;
  localparam logic [2:0]  HeaderLen = 3'd4;
  localparam logic [RunW-1:0] MaxRun = 6'd63;

  typedef enum logic [1:0] {
    ST_PIXEL      = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_TRUNCATED  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_STAT
  } ctl_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic run_step;
    logic stat_step;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_run;
    logic start_stat;
    logic run_last;
    logic run_to_stat;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/rfid_if.sv
// request channel interfaces: encoded byte input and decoded result output
// depends on nothing; payload widths follow the block's field list
interface rfid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       end_of_resource;

  modport source (output valid, output stream_byte, output end_of_resource, input ready);
  modport sink   (input valid, input stream_byte, input end_of_resource, output ready);
endinterface

interface rfid_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] pixel_value;
  logic [8:0] pixel_x;
  logic [8:0] pixel_y;
  logic       last_of_run;
  logic       image_done;

  modport source (output valid, output status, output pixel_value, output pixel_x,
                  output pixel_y, output last_of_run, output image_done, input ready);
  modport sink   (input valid, input status, input pixel_value, input pixel_x,
                  input pixel_y, input last_of_run, input image_done, output ready);
endinterface

### rtl/rfid_ctrl.sv
// controller state machine: sequences byte acceptance, pixel runs and status results
// depends on rfid_pkg
module rfid_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rfid_pkg::dp_sts_t  sts_i,
  output rfid_pkg::ctl_cmd_t cmd_o
);
  import rfid_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.start_run) begin
            state_d = S_RUN;
          end else if (sts_i.start_stat) begin
            state_d = S_STAT;
          end
        end
      end
      S_RUN: begin
        if (sts_i.out_free) begin
          cmd_o.run_step = 1'b1;
          if (sts_i.run_to_stat) begin
            state_d = S_STAT;
          end else if (sts_i.run_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_STAT: begin
        if (sts_i.out_free) begin
          cmd_o.stat_step = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### rtl/rfid_dp.sv
// datapath: header capture, run/cursor registers and the result output register
// depends on rfid_pkg and the assertion macro header
`include "rle_face_image_decoder_unit_macros.svh"
module rfid_dp #(
  parameter int unsigned MAX_DIM = rfid_pkg::MaxDim
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rfid_pkg::ctl_cmd_t cmd_i,
  output rfid_pkg::dp_sts_t  sts_o,
  input  logic [7:0]         stream_byte_i,
  input  logic               end_of_resource_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         status_o,
  output logic [7:0]         pixel_value_o,
  output logic [8:0]         pixel_x_o,
  output logic [8:0]         pixel_y_o,
  output logic               last_of_run_o,
  output logic               image_done_o
);
  import rfid_pkg::*;

  localparam int unsigned DimW = $clog2(MAX_DIM + 1);
  localparam logic [15:0] MaxDim16 = 16'(MAX_DIM);

  // decoder state
  logic [2:0]      hdr_pos_q, hdr_pos_d;
  logic [15:0]     raw_w_q, raw_w_d, raw_h_q, raw_h_d;
  logic [DimW-1:0] col_q, col_d, row_q, row_d;
  logic [RunW-1:0] run_len_q, run_len_d, cnt_q, cnt_d;
  logic            await_q, await_d, disc_q, disc_d;
  logic [7:0]      pix_q, pix_d;
  logic            end_q, end_d, cap_q, cap_d;
  status_e         stat_q, stat_d;

  // output register
  logic            out_vld_q, out_vld_d, out_load;
  status_e         o_status_q, o_status_d;
  logic [7:0]      o_val_q, o_val_d;
  logic [8:0]      o_x_q, o_x_d, o_y_q, o_y_d;
  logic            o_last_q, o_last_d, o_done_q, o_done_d;

  logic [15:0] col_ext, row_ext, col_inc, row_inc, new_h;
  logic        wrap, full_after, drop, dims_ok, clear;
  logic        is_hdr, hdr_final, is_count;

  assign col_ext    = 16'(col_q);
  assign row_ext    = 16'(row_q);
  assign col_inc    = col_ext + 16'd1;
  assign row_inc    = row_ext + 16'd1;
  assign wrap       = (col_inc >= raw_w_q);
  assign full_after = wrap && (row_inc >= raw_h_q);
  assign drop       = (cnt_q == RunW'(1)) && cap_q && !full_after;

  assign new_h     = {stream_byte_i, raw_h_q[7:0]};
  assign dims_ok   = (raw_w_q != 16'd0) && (raw_w_q <= MaxDim16) &&
                     (new_h != 16'd0) && (new_h <= MaxDim16);
  assign is_hdr    = !disc_q && (hdr_pos_q != HeaderLen);
  assign hdr_final = (hdr_pos_q == HeaderLen - 3'd1);
  assign is_count  = !disc_q && !is_hdr && await_q && (stream_byte_i > RunBase);

  always_comb begin
    sts_o.start_run   = !disc_q && !is_hdr && !is_count;
    sts_o.start_stat  = (is_hdr && !hdr_final && end_of_resource_i) ||
                        (is_hdr && hdr_final && (!dims_ok || end_of_resource_i)) ||
                        (is_count && end_of_resource_i);
    sts_o.run_last    = drop || full_after || (cnt_q == RunW'(1));
    sts_o.run_to_stat = !drop && !full_after && (cnt_q == RunW'(1)) && end_q;
    sts_o.out_free    = !out_vld_q || out_ready_i;
  end

  always_comb begin
    hdr_pos_d  = hdr_pos_q;
    raw_w_d    = raw_w_q;
    raw_h_d    = raw_h_q;
    col_d      = col_q;
    row_d      = row_q;
    run_len_d  = run_len_q;
    cnt_d      = cnt_q;
    await_d    = await_q;
    disc_d     = disc_q;
    pix_d      = pix_q;
    end_d      = end_q;
    cap_d      = cap_q;
    stat_d     = stat_q;
    clear      = 1'b0;
    out_load   = 1'b0;
    o_status_d = ST_PIXEL;
    o_val_d    = 8'd0;
    o_x_d      = 9'd0;
    o_y_d      = 9'd0;
    o_last_d   = 1'b1;
    o_done_d   = 1'b0;

    if (cmd_i.accept) begin
      if (disc_q) begin
        clear = end_of_resource_i;
      end else if (is_hdr) begin
        case (hdr_pos_q)
          3'd0:    raw_w_d = {8'h00, stream_byte_i};
          3'd1:    raw_w_d = {stream_byte_i, raw_w_q[7:0]};
          3'd2:    raw_h_d = {8'h00, stream_byte_i};
          default: raw_h_d = new_h;
        endcase
        hdr_pos_d = hdr_pos_q + 3'd1;
        if (!hdr_final) begin
          if (end_of_resource_i) begin
            stat_d = ST_BAD_HEADER;
            clear  = 1'b1;
          end
        end else if (!dims_ok) begin
          stat_d = ST_BAD_HEADER;
          if (end_of_resource_i) begin
            clear = 1'b1;
          end else begin
            disc_d = 1'b1;
          end
        end else begin
          col_d     = '0;
          row_d     = '0;
          run_len_d = RunW'(1);
          await_d   = 1'b1;
          if (end_of_resource_i) begin
            stat_d = ST_TRUNCATED;
            clear  = 1'b1;
          end
        end
      end else if (is_count) begin
        run_len_d = RunW'(stream_byte_i - RunBase);
        await_d   = 1'b0;
        if (end_of_resource_i) begin
          stat_d = ST_TRUNCATED;
          clear  = 1'b1;
        end
      end else begin
        pix_d     = stream_byte_i;
        cnt_d     = run_len_q;
        end_d     = end_of_resource_i;
        cap_d     = end_of_resource_i && (run_len_q == MaxRun);
        run_len_d = RunW'(1);
        await_d   = 1'b1;
      end
    end else if (cmd_i.run_step) begin
      out_load = 1'b1;
      if (drop) begin
        // a capped final run gives up its last pixel to the truncation result
        o_status_d = ST_TRUNCATED;
        clear      = 1'b1;
      end else begin
        o_val_d  = pix_q;
        o_x_d    = col_ext[8:0];
        o_y_d    = row_ext[8:0];
        o_done_d = full_after;
        o_last_d = full_after || ((cnt_q == RunW'(1)) && !end_q);
        col_d    = wrap ? '0 : DimW'(col_inc);
        row_d    = wrap ? DimW'(row_inc) : row_q;
        cnt_d    = cnt_q - RunW'(1);
        if (full_after) begin
          if (end_q) begin
            clear = 1'b1;
          end else begin
            disc_d = 1'b1;
          end
        end else if ((cnt_q == RunW'(1)) && end_q) begin
          stat_d = ST_TRUNCATED;
          clear  = 1'b1;
        end
      end
    end else if (cmd_i.stat_step) begin
      out_load   = 1'b1;
      o_status_d = stat_q;
    end

    if (clear) begin
      hdr_pos_d = 3'd0;
      raw_w_d   = 16'd0;
      raw_h_d   = 16'd0;
      col_d     = '0;
      row_d     = '0;
      run_len_d = RunW'(1);
      await_d   = 1'b1;
      disc_d    = 1'b0;
    end

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q <= 3'd0;
      raw_w_q   <= 16'd0;
      raw_h_q   <= 16'd0;
      col_q     <= '0;
      row_q     <= '0;
      run_len_q <= RunW'(1);
      await_q   <= 1'b1;
      disc_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      hdr_pos_q <= hdr_pos_d;
      raw_w_q   <= raw_w_d;
      raw_h_q   <= raw_h_d;
      col_q     <= col_d;
      row_q     <= row_d;
      run_len_q <= run_len_d;
      await_q   <= await_d;
      disc_q    <= disc_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q  <= pix_d;
    cnt_q  <= cnt_d;
    end_q  <= end_d;
    cap_q  <= cap_d;
    stat_q <= stat_d;
    if (out_load) begin
      o_status_q <= o_status_d;
      o_val_q    <= o_val_d;
      o_x_q      <= o_x_d;
      o_y_q      <= o_y_d;
      o_last_q   <= o_last_d;
      o_done_q   <= o_done_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = o_status_q;
  assign pixel_value_o = o_val_q;
  assign pixel_x_o     = o_x_q;
  assign pixel_y_o     = o_y_q;
  assign last_of_run_o = o_last_q;
  assign image_done_o  = o_done_q;

  `RFID_ASSERT_IMP(a_load_into_free, clk_i, rst_ni, cmd_i.run_step || cmd_i.stat_step, !out_vld_q || out_ready_i)
  `RFID_ASSERT_NXT(a_load_shows, clk_i, rst_ni, cmd_i.run_step || cmd_i.stat_step, out_vld_q)
  `RFID_ASSERT_IMP(a_status_is_last, clk_i, rst_ni, out_vld_q && (o_status_q != ST_PIXEL), o_last_q)
  `RFID_ASSERT_IMP(a_done_is_last, clk_i, rst_ni, out_vld_q && o_done_q, o_last_q && (o_status_q == ST_PIXEL))

endmodule

### rtl/rle_face_image_decoder_unit.sv
// Run-length face image decoder: takes one resource byte per request (a 4-byte header of
// little-endian width and height, each 1..MAX_DIM, then PCX-style count/value bytes) and
// returns pixels in raster order with their column and row, or a single bad-header or
// truncated-stream status. A header or count byte is accepted in the idle state and, when it
// ends in a status result, the status goes out from the stat state; a value byte is accepted
// and its run (up to 63 pixels) goes out one pixel per free output slot through the single
// result register, waiting while the result side holds ready low. A truncation status after
// the last run also goes out from the stat state. Bytes after the image is full are taken
// one per cycle.
// Depends on rfid_pkg, the rfid_in_if/rfid_out_if interfaces, rfid_ctrl and rfid_dp.
module rle_face_image_decoder_unit #(
  parameter int unsigned MAX_DIM = rfid_pkg::MaxDim
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rfid_in_if.sink    req_i,
  rfid_out_if.source res_o
);
  import rfid_pkg::*;

  // command and status between the sequencer and the datapath
  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // controller: idle takes a byte, run state emits one pixel per free output slot,
  // stat state emits the pending status result
  rfid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: header and cursor registers plus the result register that parts
  // the output side from the input side
  rfid_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .stream_byte_i     (req_i.stream_byte),
    .end_of_resource_i (req_i.end_of_resource),
    .out_ready_i       (res_o.ready),
    .out_valid_o       (res_o.valid),
    .status_o          (res_o.status),
    .pixel_value_o     (res_o.pixel_value),
    .pixel_x_o         (res_o.pixel_x),
    .pixel_y_o         (res_o.pixel_y),
    .last_of_run_o     (res_o.last_of_run),
    .image_done_o      (res_o.image_done)
  );

endmodule
